@@ rtl/dq_pkg.sv @@
// shared types and codes for the descriptor queue block
package dq_pkg;

  localparam int DEF_ENTRIES     = 16;
  localparam int DEF_HANDLE_BITS = 32;

  localparam logic [1:0] OP_APPEND     = 2'd0;
  localparam logic [1:0] OP_REMOVE_HDL = 2'd1;
  localparam logic [1:0] OP_REMOVE_TOP = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FREE  = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;
  localparam logic [1:0] ST_INVALID  = 2'd3;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_LOAD = 2'd1;
  localparam logic [1:0] CELL_NEXT = 2'd2;
  localparam logic [1:0] CELL_HEAD = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        queue_select;
    logic [31:0] buffer_handle;
    logic [15:0] length;
    logic [15:0] offset;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] handle_out;
    logic [15:0] length_out;
    logic [15:0] offset_out;
    logic        receive_nonempty;
    logic        transmit_nonempty;
    logic        receive_free_available;
    logic        transmit_free_available;
  } out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rot;
  } chain_cmd_t;

  typedef struct packed {
    logic [1:0] mode;
  } cell_ctl_t;

endpackage

@@ rtl/dq_cell.sv @@
// one storage cell of a descriptor chain
module dq_cell import dq_pkg::*; #(
  parameter int HANDLE_BITS = DEF_HANDLE_BITS
) (
  input  logic                   clk,
  input  cell_ctl_t              ctl,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [15:0]            new_length,
  input  logic [15:0]            new_offset,
  input  logic [HANDLE_BITS-1:0] next_handle,
  input  logic [15:0]            next_length,
  input  logic [15:0]            next_offset,
  input  logic [HANDLE_BITS-1:0] head_handle,
  input  logic [15:0]            head_length,
  input  logic [15:0]            head_offset,
  output logic [HANDLE_BITS-1:0] q_handle,
  output logic [15:0]            q_length,
  output logic [15:0]            q_offset
);

  logic [HANDLE_BITS-1:0] handle_r;
  logic [15:0]            length_r;
  logic [15:0]            offset_r;

  always_ff @(posedge clk) begin
    case (ctl.mode)
      CELL_LOAD: begin
        handle_r <= new_handle;
        length_r <= new_length;
        offset_r <= new_offset;
      end
      CELL_NEXT: begin
        handle_r <= next_handle;
        length_r <= next_length;
        offset_r <= next_offset;
      end
      CELL_HEAD: begin
        handle_r <= head_handle;
        length_r <= head_length;
        offset_r <= head_offset;
      end
      default: ;
    endcase
  end

  assign q_handle = handle_r;
  assign q_length = length_r;
  assign q_offset = offset_r;

endmodule

@@ rtl/dq_chain.sv @@
// ordered chain of cells holding one queue, head at cell 0
module dq_chain import dq_pkg::*; #(
  parameter int ENTRIES_PER_QUEUE = DEF_ENTRIES,
  parameter int HANDLE_BITS       = DEF_HANDLE_BITS,
  localparam int CW = $clog2(ENTRIES_PER_QUEUE + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  chain_cmd_t             cmd,
  input  logic [HANDLE_BITS-1:0] wr_handle,
  input  logic [15:0]            wr_length,
  input  logic [15:0]            wr_offset,
  output logic [HANDLE_BITS-1:0] head_handle,
  output logic [15:0]            head_length,
  output logic [15:0]            head_offset,
  output logic [CW-1:0]          count
);

  localparam int N = ENTRIES_PER_QUEUE;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [HANDLE_BITS-1:0] q_h [N];
  logic [15:0]            q_l [N];
  logic [15:0]            q_o [N];

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_cell
      cell_ctl_t ctl;
      logic [HANDLE_BITS-1:0] nh;
      logic [15:0] nl, no;
      // last cell has no neighbor, never shifts in
      if (i == N - 1) begin : g_last
        assign nh = q_h[i];
        assign nl = q_l[i];
        assign no = q_o[i];
      end else begin : g_mid
        assign nh = q_h[i+1];
        assign nl = q_l[i+1];
        assign no = q_o[i+1];
      end
      always_comb begin
        ctl.mode = CELL_HOLD;
        if (cmd.push && cnt_r == CW'(i)) ctl.mode = CELL_LOAD;
        else if ((cmd.pop || cmd.rot) && CW'(i + 1) < cnt_r) ctl.mode = CELL_NEXT;
        else if (cmd.rot && CW'(i + 1) == cnt_r) ctl.mode = CELL_HEAD;
      end
      dq_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
        .clk(clk), .ctl(ctl),
        .new_handle(wr_handle), .new_length(wr_length), .new_offset(wr_offset),
        .next_handle(nh), .next_length(nl), .next_offset(no),
        .head_handle(q_h[0]), .head_length(q_l[0]), .head_offset(q_o[0]),
        .q_handle(q_h[i]), .q_length(q_l[i]), .q_offset(q_o[i])
      );
    end
  endgenerate

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.push) cnt_nxt = cnt_r + CW'(1);
    else if (cmd.pop) cnt_nxt = cnt_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign head_handle = q_h[0];
  assign head_length = q_l[0];
  assign head_offset = q_o[0];
  assign count       = cnt_r;

endmodule

@@ rtl/descriptor_queue_with_free_list.sv @@
// top level: receive and transmit descriptor queues with free-entry accounting
//
// usage
// - in channel (in_valid/in_ready/in_data) carries one request: opcode, queue,
//   handle, length, offset. out channel returns exactly one result per request
// - each queue is a row of cells kept in queue order, head in cell 0; a free
//   entry is simply an unused cell, so the free list is the cell count
// - append and remove top are accepted, then their result is loaded
// - remove by handle rotates the whole queue through cell 0 once, one cell
//   per cycle, dropping the first match
// - one request is worked at a time; in_ready is high while idle, also while
//   an earlier result still waits in the output register
// - when the receiver stalls, a finished result waits in its own state until
//   the output register frees up, and no new request is taken meanwhile
// - synchronous reset empties both queues, so all entries are free; cell
//   contents are not cleared
module descriptor_queue_with_free_list import dq_pkg::*; #(
  parameter int ENTRIES_PER_QUEUE = DEF_ENTRIES,
  parameter int HANDLE_BITS       = DEF_HANDLE_BITS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int N  = ENTRIES_PER_QUEUE;
  localparam int CW = $clog2(N + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state_r, state_nxt;

  // latched request and search progress
  logic                   sel_r;
  logic [HANDLE_BITS-1:0] key_r;
  logic [CW-1:0]          steps_r, steps_nxt;
  logic                   found_r, found_nxt;

  // pending result fields
  logic [1:0]             res_status_r, res_status_nxt;
  logic [HANDLE_BITS-1:0] res_handle_r, res_handle_nxt;
  logic [15:0]            res_length_r, res_length_nxt;
  logic [15:0]            res_offset_r, res_offset_nxt;

  logic out_valid_r;
  out_t out_data_r;

  chain_cmd_t             cmd [2];
  logic [HANDLE_BITS-1:0] hd_h [2];
  logic [15:0]            hd_l [2];
  logic [15:0]            hd_o [2];
  logic [CW-1:0]          cnt  [2];

  logic [HANDLE_BITS-1:0] h_in;
  logic [15:0]            off_in;
  logic                   in_fire;
  logic                   q_in;
  logic                   head_hit;

  assign h_in    = HANDLE_BITS'(in_data.buffer_handle);
  assign q_in    = in_data.queue_select;
  assign off_in  = q_in ? 16'd0 : in_data.offset;  // transmit offset forced to zero
  assign in_ready = (state_r == S_IDLE);
  assign in_fire = in_valid && in_ready;
  assign head_hit = (hd_h[sel_r] == key_r);

  genvar g;
  generate
    for (g = 0; g < 2; g++) begin : g_q
      dq_chain #(.ENTRIES_PER_QUEUE(N), .HANDLE_BITS(HANDLE_BITS)) u_chain (
        .clk(clk), .rst_n(rst_n), .cmd(cmd[g]),
        .wr_handle(h_in), .wr_length(in_data.length), .wr_offset(off_in),
        .head_handle(hd_h[g]), .head_length(hd_l[g]), .head_offset(hd_o[g]),
        .count(cnt[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt      = state_r;
    steps_nxt      = steps_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_handle_nxt = res_handle_r;
    res_length_nxt = res_length_r;
    res_offset_nxt = res_offset_r;
    cmd[0] = '0;
    cmd[1] = '0;
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_status_nxt = ST_OK;
          res_handle_nxt = '0;
          res_length_nxt = '0;
          res_offset_nxt = '0;
          state_nxt      = S_DONE;
          case (in_data.opcode)
            OP_APPEND: begin
              if (q_in && (h_in == '0 || in_data.length == 16'd0)) begin
                res_status_nxt = ST_INVALID;
              end else if (cnt[q_in] == CW'(N)) begin
                res_status_nxt = ST_NO_FREE;
              end else begin
                cmd[q_in].push = 1'b1;
              end
            end
            OP_REMOVE_HDL: begin
              if (cnt[q_in] == '0) begin
                res_status_nxt = ST_NOT_FND;
              end else begin
                // walk every entry once through the head cell
                steps_nxt = cnt[q_in];
                found_nxt = 1'b0;
                state_nxt = S_SRCH;
              end
            end
            OP_REMOVE_TOP: begin
              if (cnt[q_in] == '0) begin
                res_status_nxt = ST_NOT_FND;
              end else begin
                res_handle_nxt = hd_h[q_in];
                res_length_nxt = hd_l[q_in];
                res_offset_nxt = hd_o[q_in];
                cmd[q_in].pop  = 1'b1;
              end
            end
            default: res_status_nxt = ST_INVALID;
          endcase
        end
      end
      S_SRCH: begin
        // first match is dropped, every other entry goes to the back
        if (!found_r && head_hit) begin
          cmd[sel_r].pop = 1'b1;
          found_nxt = 1'b1;
        end else begin
          cmd[sel_r].rot = 1'b1;
        end
        steps_nxt = steps_r - CW'(1);
        if (steps_r == CW'(1)) begin
          res_status_nxt = (found_r || head_hit) ? ST_OK : ST_NOT_FND;
          state_nxt      = S_DONE;
        end
      end
      S_DONE: begin
        // hold here while the receiver still owns the output register
        if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire) begin
      sel_r <= q_in;
      key_r <= h_in;
    end
    steps_r      <= steps_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_handle_r <= res_handle_nxt;
    res_length_r <= res_length_nxt;
    res_offset_r <= res_offset_nxt;
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_data_r.status                  <= res_status_r;
      out_data_r.handle_out              <= 32'(res_handle_r);
      out_data_r.length_out              <= res_length_r;
      out_data_r.offset_out              <= res_offset_r;
      out_data_r.receive_nonempty        <= (cnt[0] != '0);
      out_data_r.transmit_nonempty       <= (cnt[1] != '0);
      out_data_r.receive_free_available  <= (cnt[0] != CW'(N));
      out_data_r.transmit_free_available <= (cnt[1] != CW'(N));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // occupancy never passes the pool size
  a_rx_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt[0] <= CW'(N))
    else $error("receive count overflow");
  a_tx_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt[1] <= CW'(N))
    else $error("transmit count overflow");
  // search walk always has entries left to visit
  a_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SRCH |-> (steps_r != '0 && steps_r <= CW'(N)))
    else $error("search step count out of range");
  // the last search step always leads to the result state
  a_srch_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH && steps_r == CW'(1)) |=> state_r == S_DONE)
    else $error("search did not finish");

endmodule
